>>> src/mfmd_pkg.sv
// ============================================================================
// Motor feedback decoder package
// Shared types, register codes and constants of the multi-turn decoder.
// ============================================================================
`default_nettype none

package mfmd_pkg;

    // Fixed field widths.
    localparam int ID_W     = 11;
    localparam int ANGLE_W  = 13;
    localparam int WORD_W   = 16;
    localparam int TEMP_W   = 8;
    localparam int CURR_W   = 14;
    localparam int TURN_W   = 19;
    localparam int TOTAL_W  = 32;
    localparam int CNT_W    = 6;
    localparam int SPIN_W   = 15;
    localparam int JUMP_W   = 13;
    localparam int OUT_IDX_W = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_FRAMES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ID        = 2'd3;

    localparam logic [SPIN_W-1:0] SPIN_THRESHOLD_RST = 15'd10;
    localparam logic [JUMP_W-1:0] JUMP_THRESHOLD_RST = 13'd50;
    localparam logic [CNT_W-1:0]  CALIB_FRAMES_RST   = 6'd50;
    localparam logic [ID_W-1:0]   BASE_ID_RST        = 11'd513;

    // Request kinds carried in the input tuser.
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Encoder resolution and saturation limits.
    localparam int COUNTS_PER_TURN = 8192;
    localparam logic [TOTAL_W-1:0] CPT_WORD = 32'(COUNTS_PER_TURN);
    localparam logic signed [TURN_W-1:0] TURN_MAX = 19'sd262143;
    localparam logic signed [TURN_W-1:0] TURN_MIN = -19'sd262144;
    localparam logic [CNT_W-1:0] FRAME_CNT_MAX = 6'd63;

    // Reciprocal of five for 16-bit magnitudes: q = (x * 52429) >> 18.
    localparam logic [31:0] DIV5_MAGIC = 32'd52429;
    localparam int DIV5_SHIFT = 18;

    typedef struct packed {
        logic [SPIN_W-1:0] spin_threshold;
        logic [JUMP_W-1:0] jump_threshold;
        logic [CNT_W-1:0]  calib_frames;
        logic [ID_W-1:0]   base_id;
    } mfmd_cfg_t;

    typedef struct packed {
        logic                     req_type;
        logic [ID_W-1:0]          frame_id;
        logic [ANGLE_W-1:0]       rotor_angle;
        logic signed [WORD_W-1:0] speed_word;
        logic signed [WORD_W-1:0] current_word;
        logic [TEMP_W-1:0]        temp_byte;
    } mfmd_item_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]      motor_index;
        logic signed [WORD_W-1:0]  speed_out;
        logic signed [CURR_W-1:0]  current_div;
        logic [TEMP_W-1:0]         temperature;
        logic [ANGLE_W-1:0]        angle_out;
        logic signed [TURN_W-1:0]  turn_count;
        logic signed [TOTAL_W-1:0] angle_total;
    } mfmd_result_t;

    // Signed division by minus five, truncating toward zero.
    function automatic logic signed [CURR_W-1:0] div_neg5(input logic signed [WORD_W-1:0] cur);
        logic [WORD_W-1:0]  mag;
        logic [31:0]        prod;
        logic [CURR_W-1:0]  q;
        mag  = cur[WORD_W-1] ? (~cur + 16'd1) : cur;
        prod = {16'd0, mag} * DIV5_MAGIC;
        q    = {1'b0, prod[DIV5_SHIFT+12:DIV5_SHIFT]};
        return cur[WORD_W-1] ? $signed(q) : $signed(~q + 14'd1);
    endfunction

endpackage

`default_nettype wire

>>> src/mfmd_cfg.sv
// ============================================================================
// Configuration registers
// Holds the thresholds, calibration length and base identifier.
// ============================================================================
`default_nettype none

module mfmd_cfg
    import mfmd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output mfmd_cfg_t                  cfg
);

    mfmd_cfg_t cfg_reg;
    mfmd_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SPIN_THRESHOLD: cfg_next.spin_threshold = cfg_data[SPIN_W-1:0];
                CFG_JUMP_THRESHOLD: cfg_next.jump_threshold = cfg_data[JUMP_W-1:0];
                CFG_CALIB_FRAMES:   cfg_next.calib_frames   = cfg_data[CNT_W-1:0];
                CFG_BASE_ID:        cfg_next.base_id        = cfg_data[ID_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spin_threshold <= SPIN_THRESHOLD_RST;
            cfg_reg.jump_threshold <= JUMP_THRESHOLD_RST;
            cfg_reg.calib_frames   <= CALIB_FRAMES_RST;
            cfg_reg.base_id        <= BASE_ID_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> src/mfmd_unwrap.sv
// ============================================================================
// Per-motor angle unwrap
// Holds the state of each motor and turns one frame into at most one result.
// ============================================================================
`default_nettype none

module mfmd_unwrap
    import mfmd_pkg::*;
#(
    parameter int MOTOR_COUNT = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mfmd_cfg_t  cfg,
    input  wire logic       item_en,
    input  wire mfmd_item_t item,
    output logic            res_valid,
    output mfmd_result_t    res
);

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    logic [CNT_W-1:0]         frame_cnt_reg  [MOTOR_COUNT];
    logic [ANGLE_W-1:0]       angle_reg      [MOTOR_COUNT];
    logic [ANGLE_W-1:0]       offset_reg     [MOTOR_COUNT];
    logic signed [TURN_W-1:0] turn_reg       [MOTOR_COUNT];

    logic [CNT_W-1:0]         frame_cnt_next;
    logic [ANGLE_W-1:0]       offset_next;
    logic signed [TURN_W-1:0] turn_next;

    logic [ID_W:0]            id_diff;
    logic                     hit;
    logic [IDX_W-1:0]         idx;
    logic [CNT_W-1:0]         cnt;
    logic                     calib;
    logic [ANGLE_W-1:0]       prev_angle;
    logic signed [TURN_W-1:0] turn_cur;
    logic signed [ANGLE_W:0]  delta;
    logic signed [ANGLE_W:0]  jt_pos;
    logic signed [ANGLE_W:0]  jt_neg;
    logic signed [WORD_W:0]   speed_ext;
    logic signed [WORD_W:0]   st_pos;
    logic signed [WORD_W:0]   st_neg;
    logic                     fwd;
    logic                     rev;
    logic                     turn_up;
    logic                     turn_down;
    logic [TOTAL_W-1:0]       turn_base;
    logic [TOTAL_W-1:0]       turn_step;
    logic                     is_frame;
    logic                     is_clear;

    assign is_clear = item_en && (item.req_type == REQ_CLEAR);
    assign is_frame = item_en && (item.req_type == REQ_FRAME);

    assign id_diff = {1'b0, item.frame_id} - {1'b0, cfg.base_id};
    assign hit     = !id_diff[ID_W] && (id_diff[ID_W-1:0] < ID_W'(MOTOR_COUNT));
    assign idx     = id_diff[IDX_W-1:0];

    assign cnt        = frame_cnt_reg[idx];
    assign prev_angle = angle_reg[idx];
    assign turn_cur   = turn_reg[idx];
    assign calib      = (cnt <= cfg.calib_frames);

    assign frame_cnt_next = (cnt < FRAME_CNT_MAX) ? cnt + 6'd1 : cnt;
    assign offset_next    = calib ? item.rotor_angle : offset_reg[idx];

    // Wrap detection: a large drop while spinning forward, or a large rise
    // while spinning backward, means the angle crossed zero.
    assign delta     = $signed({1'b0, item.rotor_angle}) - $signed({1'b0, prev_angle});
    assign jt_pos    = $signed({1'b0, cfg.jump_threshold});
    assign jt_neg    = -jt_pos;
    assign speed_ext = {item.speed_word[WORD_W-1], item.speed_word};
    assign st_pos    = $signed({2'b00, cfg.spin_threshold});
    assign st_neg    = -st_pos;
    assign fwd       = speed_ext > st_pos;
    assign rev       = speed_ext < st_neg;

    assign turn_up   = fwd && !(delta >= jt_pos) && (delta <= jt_neg) && (turn_cur != TURN_MAX);
    assign turn_down = !fwd && rev && !(delta <= jt_neg) && (delta >= jt_pos)
                       && (turn_cur != TURN_MIN);

    assign turn_next = turn_up ? turn_cur + 19'sd1 : (turn_down ? turn_cur - 19'sd1 : turn_cur);

    // The product uses the stored count; the step adds the change of this frame.
    assign turn_base = {{(TOTAL_W-TURN_W){turn_cur[TURN_W-1]}}, turn_cur} * CPT_WORD;
    assign turn_step = turn_up ? CPT_WORD : (turn_down ? (~CPT_WORD + 32'd1) : '0);

    assign res_valid = is_frame && hit && !calib;

    always_comb
    begin
        res.motor_index   = id_diff[OUT_IDX_W-1:0];
        res.speed_out     = item.speed_word;
        res.current_div   = div_neg5(item.current_word);
        res.temperature   = item.temp_byte;
        res.angle_out     = item.rotor_angle;
        res.turn_count    = turn_next;
        res.angle_total   = $signed(turn_base + turn_step
                                    + {{(TOTAL_W-ANGLE_W){1'b0}}, item.rotor_angle}
                                    - {{(TOTAL_W-ANGLE_W){1'b0}}, offset_reg[idx]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTOR_COUNT; m++)
            begin
                frame_cnt_reg[m] <= '0;
                angle_reg[m]     <= '0;
                offset_reg[m]    <= '0;
                turn_reg[m]      <= '0;
            end
        end
        else if (is_clear)
        begin
            for (int m = 0; m < MOTOR_COUNT; m++)
            begin
                frame_cnt_reg[m] <= '0;
                angle_reg[m]     <= '0;
                offset_reg[m]    <= '0;
                turn_reg[m]      <= '0;
            end
        end
        else if (is_frame && hit)
        begin
            frame_cnt_reg[idx] <= frame_cnt_next;
            angle_reg[idx]     <= item.rotor_angle;
            offset_reg[idx]    <= offset_next;
            if (!calib)
            begin
                turn_reg[idx] <= turn_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/motor_feedback_multiturn_decoder_core.sv
// Pipeline: a transaction is held in the input register, its result in the
// output register. Throughput: one transaction per cycle while the result
// sink keeps up; each motor's state is read and written back in the same
// cycle, so frames of the same motor may follow each other directly.
// Reset: rst_n clears the configuration to its defaults, all motor state to
// zero and both pipeline registers to empty, at once and without a sweep.
// ============================================================================
// Multi-turn motor feedback decoder
// Unwraps the rotor angles of a group of motors into turn counts and totals.
// ============================================================================
`default_nettype none

module motor_feedback_multiturn_decoder_core
    import mfmd_pkg::*;
#(
    parameter int MOTOR_COUNT = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: frame_id[10:0], rotor_angle[23:11], speed_word[39:24],
    // current_word[55:40], temp_byte[63:56].
    input  wire logic [63:0]           s_axis_tdata,
    // Fields from bit 0: req_type[0].
    input  wire logic [0:0]            s_axis_tuser,

    // Result stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0: speed_out[15:0], current_div[29:16],
    // temperature[37:30], angle_out[50:38], turn_count[69:51],
    // angle_total[101:70], zero fill[103:102].
    output logic [103:0]               m_axis_tdata,
    // Fields from bit 0: motor_index[1:0].
    output logic [1:0]                 m_axis_tuser,

    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    mfmd_cfg_t    cfg;

    logic         in_valid_reg;
    logic         in_valid_next;
    mfmd_item_t   in_item_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    mfmd_result_t out_res_reg;

    logic         s_fire;
    logic         advance;
    logic         item_go;
    logic         res_valid;
    mfmd_result_t res;

    mfmd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The output register moves whenever it is empty or being taken. The
    // input register then hands its item over, and can take a new one in the
    // same cycle, so the stream runs at full rate while the sink keeps up.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign item_go       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    mfmd_unwrap #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_unwrap
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_en   (item_go),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (item_go)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? (item_go && res_valid) : out_valid_reg;
    end

    // Control flags are reset; the payload registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.req_type     <= s_axis_tuser[0];
            in_item_reg.frame_id     <= s_axis_tdata[10:0];
            in_item_reg.rotor_angle  <= s_axis_tdata[23:11];
            in_item_reg.speed_word   <= $signed(s_axis_tdata[39:24]);
            in_item_reg.current_word <= $signed(s_axis_tdata[55:40]);
            in_item_reg.temp_byte    <= s_axis_tdata[63:56];
        end
        if (advance && item_go && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.motor_index;
    assign m_axis_tdata  = {2'b00,
                            out_res_reg.angle_total,
                            out_res_reg.turn_count,
                            out_res_reg.angle_out,
                            out_res_reg.temperature,
                            out_res_reg.current_div,
                            out_res_reg.speed_out};

endmodule

`default_nettype wire

>>> src/mfmd_checker.sv
// ============================================================================
// Decoder port checker
// Watches the stream ports of the decoder for ordering and flow errors.
// ============================================================================
`default_nettype none

module mfmd_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [0:0]   s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata
);

    // A stalled result keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // With no result waiting, the input side must be open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output empty");

    // A new result always comes from an earlier accepted input transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching input transaction");

    // A clear request never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |-> ##2 !$rose(m_axis_tvalid))
        else $error("clear request produced a result");

endmodule

bind motor_feedback_multiturn_decoder_core mfmd_checker u_mfmd_checker (.*);

`default_nettype wire

>>> dv/tb_top.sv
// ============================================================================
// Multi-turn decoder testbench
// Drives feedback frames and clear requests into the decoder core, predicts
// every result from a local model of the per-motor unwrap state, and compares
// each result transaction field by field. Named tests run in turn: reset
// values, hand-picked cases, the frame counter at its top, a long receiver
// hold-off, random traffic under several register settings and idle
// patterns, and long runs of turns in either direction.
// ============================================================================

module tb_top
    import mfmd_pkg::*;
();

    localparam int MOTOR_COUNT = 4;

    // Items that give no result may still be in flight in the core's input and
    // output registers when the last result has come, so the drain before a
    // register write waits this long beyond it.
    localparam int DRAIN_CYCLES = 8;

    // Length of the receiver hold-off in the backpressure test.
    localparam int HOLD_CYCLES = 400;

    // Frames per direction in the turn run test.
    localparam int RUN_FRAMES = 60;

    // The limit has to cover the slowest correct run: random traffic with
    // both sides idling, drains, register writes and the hold-off.
    localparam int LIMIT_CYCLES = 50000;

    // Only the first mismatches are printed; all of them are counted.
    localparam int MAX_REPORTS = 100;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    logic                  clk = 1'b0;
    logic                  rst_n;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // Fields from bit 0: frame_id[10:0], rotor_angle[23:11], speed_word[39:24],
    // current_word[55:40], temp_byte[63:56].
    logic [63:0]           s_axis_tdata;
    // Fields from bit 0: req_type[0].
    logic [0:0]            s_axis_tuser;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // Fields from bit 0: speed_out[15:0], current_div[29:16],
    // temperature[37:30], angle_out[50:38], turn_count[69:51],
    // angle_total[101:70], zero fill[103:102].
    logic [103:0]          m_axis_tdata;
    // Fields from bit 0: motor_index[1:0].
    logic [1:0]            m_axis_tuser;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    motor_feedback_multiturn_decoder_core #(
        .MOTOR_COUNT(MOTOR_COUNT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Local copy of the decoder: registers and per-motor unwrap state.
    // ------------------------------------------------------------------------
    mfmd_cfg_t                 cfg_shadow;
    logic [CNT_W-1:0]          frame_count  [MOTOR_COUNT];
    logic [ANGLE_W-1:0]        seen_angle   [MOTOR_COUNT];
    logic [ANGLE_W-1:0]        zero_angle   [MOTOR_COUNT];
    logic signed [TURN_W-1:0]  turn_store   [MOTOR_COUNT];

    // Results predicted but not yet seen on the result stream, oldest first.
    mfmd_result_t              expected_results [$];
    int                        results_predicted = 0;

    // Rotor angle that the random traffic walks along, per motor.
    logic [ANGLE_W-1:0]        drive_angle [MOTOR_COUNT];

    idle_mode_e                idle_mode = IDLE_NONE;
    int                        err_count = 0;
    int                        cycle_count = 0;

    // The hold-off is requested by bumping hold_req_id; its own process
    // notices the change at a rising edge and counts the cycles down.
    int unsigned               hold_req_id = 0;
    int unsigned               hold_seen_id = 0;
    int unsigned               hold_left = 0;

    task automatic clear_odometry();
        for (int k = 0; k < MOTOR_COUNT; k++)
        begin
            frame_count[k] = '0;
            seen_angle[k]  = '0;
            zero_angle[k]  = '0;
            turn_store[k]  = '0;
        end
    endtask

    task automatic model_reset();
        cfg_shadow.spin_threshold = SPIN_THRESHOLD_RST;
        cfg_shadow.jump_threshold = JUMP_THRESHOLD_RST;
        cfg_shadow.calib_frames   = CALIB_FRAMES_RST;
        cfg_shadow.base_id        = BASE_ID_RST;
        clear_odometry();
        for (int k = 0; k < MOTOR_COUNT; k++)
            drive_angle[k] = '0;
    endtask

    // Updates the unwrap state for one accepted input transaction and queues
    // the result that it gives, if any.
    task automatic predict_unwrap(input mfmd_item_t it);
        int           rel;
        int           cnt_old;
        int           delta;
        int           spd;
        int           jt;
        int           st;
        int           r;
        int           cur_q;
        longint       total;
        mfmd_result_t res;
        if (it.req_type == REQ_CLEAR)
        begin
            clear_odometry();
            return;
        end
        rel = int'(it.frame_id) - int'(cfg_shadow.base_id);
        if (rel < 0 || rel >= MOTOR_COUNT)
            return;

        // Every frame of the motor counts, calibration frames included.
        cnt_old = int'(frame_count[rel]);
        if (frame_count[rel] < FRAME_CNT_MAX)
            frame_count[rel] = frame_count[rel] + 1'b1;
        if (cnt_old <= int'(cfg_shadow.calib_frames))
        begin
            seen_angle[rel] = it.rotor_angle;
            zero_angle[rel] = it.rotor_angle;
            return;
        end

        delta = int'(it.rotor_angle) - int'(seen_angle[rel]);
        seen_angle[rel] = it.rotor_angle;
        jt  = int'(cfg_shadow.jump_threshold);
        st  = int'(cfg_shadow.spin_threshold);
        spd = int'(it.speed_word);
        r   = int'(turn_store[rel]);

        // A large drop in forward spin is a wrap past zero; a large rise in
        // reverse spin is one the other way. A change that is large in the
        // direction of spin takes precedence and counts nothing.
        if (spd > st)
        begin
            if (delta < jt && delta <= -jt && r < int'(TURN_MAX))
                r = r + 1;
        end
        else if (spd < -st)
        begin
            if (delta > -jt && delta >= jt && r > int'(TURN_MIN))
                r = r - 1;
        end
        turn_store[rel] = r[TURN_W-1:0];

        cur_q = int'(it.current_word) / -5;
        total = longint'(r) * COUNTS_PER_TURN + longint'(it.rotor_angle)
              - longint'(zero_angle[rel]);

        res.motor_index = rel[OUT_IDX_W-1:0];
        res.speed_out   = it.speed_word;
        res.current_div = cur_q[CURR_W-1:0];
        res.temperature = it.temp_byte;
        res.angle_out   = it.rotor_angle;
        res.turn_count  = r[TURN_W-1:0];
        res.angle_total = total[TOTAL_W-1:0];
        expected_results.push_back(res);
        results_predicted++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic mfmd_item_t mk_frame(input int id, input int ang, input int spd,
                                            input int cur, input int temp);
        mfmd_item_t it;
        it.req_type     = REQ_FRAME;
        it.frame_id     = id[ID_W-1:0];
        it.rotor_angle  = ang[ANGLE_W-1:0];
        it.speed_word   = spd[WORD_W-1:0];
        it.current_word = cur[WORD_W-1:0];
        it.temp_byte    = temp[TEMP_W-1:0];
        return it;
    endfunction

    // A frame with every other field random; the caller may change the request kind.
    task automatic random_fields(output mfmd_item_t it);
        it.req_type     = REQ_FRAME;
        it.frame_id     = ID_W'($urandom);
        it.rotor_angle  = ANGLE_W'($urandom);
        it.speed_word   = WORD_W'($urandom);
        it.current_word = WORD_W'($urandom);
        it.temp_byte    = TEMP_W'($urandom);
    endtask

    // Speed word for the given spin direction, now and then inside the band
    // where the direction is not trusted or exactly on its edge.
    function automatic int pick_speed(input bit fwd);
        int st;
        int roll;
        st   = int'(cfg_shadow.spin_threshold);
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return int'($urandom_range(0, 2 * st)) - st;
        if (roll == 1)
            return fwd ? st : -st;
        if (fwd)
            return (st < 32767) ? int'($urandom_range(st + 1, 32767)) : 32767;
        return -int'($urandom_range(st + 1, 32768));
    endfunction

    // Mostly well-formed frames of the configured motors walking their angles
    // in the direction of spin, with foreign or garbage frames and a few
    // clear requests mixed in. Clears are left out when calibration is long,
    // as they would keep the motors from ever leaving it.
    task automatic make_traffic_item(output mfmd_item_t it);
        int roll;
        int m;
        int step;
        int hi;
        int clear_pct;
        bit fwd;
        random_fields(it);
        clear_pct = (cfg_shadow.calib_frames <= 3) ? 2 : 0;
        roll = $urandom_range(0, 99);
        if (roll < clear_pct)
        begin
            it.req_type = REQ_CLEAR;
            return;
        end
        if (roll < 10)
            return;
        m   = $urandom_range(0, MOTOR_COUNT - 1);
        fwd = $urandom_range(0, 1);
        hi  = 2 * int'(cfg_shadow.jump_threshold) + 2;
        if (hi > 8191)
            hi = 8191;
        step = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8191))
                                           : int'($urandom_range(0, hi));
        it.frame_id    = ID_W'(int'(cfg_shadow.base_id) + m);
        it.rotor_angle = ANGLE_W'(int'(drive_angle[m]) + (fwd ? step : -step));
        it.speed_word  = WORD_W'(pick_speed(fwd));
        drive_angle[m] = it.rotor_angle;
    endtask

    function automatic bit sender_gap();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 49;
            IDLE_BOTH:   return $urandom_range(0, 99) < 33;
            default:     return 1'b0;
        endcase
    endfunction

    // Offers one item and returns once the transaction has happened. The
    // valid stays high afterwards, so back-to-back items need no extra edge.
    task automatic send_item(input mfmd_item_t it);
        @(negedge clk);
        while (sender_gap())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.temp_byte, it.current_word, it.speed_word,
                          it.rotor_angle, it.frame_id};
        s_axis_tuser  <= it.req_type;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_unwrap(it);
    endtask

    // Stops the input and waits until every predicted result has come and
    // any result-less items have left the pipeline.
    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SPIN_THRESHOLD: cfg_shadow.spin_threshold = val[SPIN_W-1:0];
            CFG_JUMP_THRESHOLD: cfg_shadow.jump_threshold = val[JUMP_W-1:0];
            CFG_CALIB_FRAMES:   cfg_shadow.calib_frames   = val[CNT_W-1:0];
            CFG_BASE_ID:        cfg_shadow.base_id        = val[ID_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int unsigned spin, input int unsigned jump,
                              input int unsigned calib, input int unsigned base);
        wait_drain();
        write_reg(CFG_SPIN_THRESHOLD, spin);
        write_reg(CFG_JUMP_THRESHOLD, jump);
        write_reg(CFG_CALIB_FRAMES, calib);
        write_reg(CFG_BASE_ID, base);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls by idle mode, and the long hold-off.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seen_id != hold_req_id)
        begin
            hold_seen_id <= hold_req_id;
            hold_left    <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
            m_axis_tready <= 1'b0;
        else
            case (idle_mode)
                IDLE_RECEIVER: m_axis_tready <= $urandom_range(0, 99) >= 49;
                IDLE_BOTH:     m_axis_tready <= $urandom_range(0, 99) >= 33;
                default:       m_axis_tready <= 1'b1;
            endcase
    end

    // ------------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("cycle %0d: %s: got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
    endtask

    always @(posedge clk)
    begin : result_check
        mfmd_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result transaction with nothing expected",
                                m_axis_tdata[31:0], '0);
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.motor_index)
                    report_mismatch("motor_index", 32'(m_axis_tuser),
                                    32'(want.motor_index));
                if (m_axis_tdata[15:0] !== want.speed_out)
                    report_mismatch("speed_out", 32'(m_axis_tdata[15:0]),
                                    32'(want.speed_out));
                if (m_axis_tdata[29:16] !== want.current_div)
                    report_mismatch("current_div", 32'(m_axis_tdata[29:16]),
                                    32'(want.current_div));
                if (m_axis_tdata[37:30] !== want.temperature)
                    report_mismatch("temperature", 32'(m_axis_tdata[37:30]),
                                    32'(want.temperature));
                if (m_axis_tdata[50:38] !== want.angle_out)
                    report_mismatch("angle_out", 32'(m_axis_tdata[50:38]),
                                    32'(want.angle_out));
                if (m_axis_tdata[69:51] !== want.turn_count)
                    report_mismatch("turn_count", 32'(m_axis_tdata[69:51]),
                                    32'(want.turn_count));
                if (m_axis_tdata[101:70] !== want.angle_total)
                    report_mismatch("angle_total", m_axis_tdata[101:70],
                                    want.angle_total);
                if (m_axis_tdata[103:102] !== 2'b00)
                    report_mismatch("zero fill", 32'(m_axis_tdata[103:102]), '0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[motor_feedback_multiturn_decoder_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // No register is written: the 52nd frame of motor zero is the first to
    // give a result only if calibration, base and thresholds reset right.
    task automatic test_reset_defaults();
        idle_mode = IDLE_NONE;
        send_item(mk_frame(512, 77, 100, 0, 1));
        for (int i = 0; i < 58; i++)
            send_item(mk_frame(513, (i * 700) % 8192, 11 + $urandom_range(0, 30),
                               int'($urandom_range(0, 65535)), int'($urandom_range(0, 255))));
        send_item(mk_frame(516, 1, 11, 0, 0));
        send_item(mk_frame(517, 1, 11, 0, 0));
    endtask

    task automatic test_directed_cases();
        mfmd_item_t it;
        set_config(10, 50, 1, 513);
        random_fields(it);
        it.req_type = REQ_CLEAR;
        send_item(it);
        // Identifiers just outside the motor range, and the top identifier.
        send_item(mk_frame(512, 8191, 500, 1, 1));
        send_item(mk_frame(517, 8191, 500, 1, 1));
        send_item(mk_frame(2047, 8191, 500, 1, 1));
        // Two calibration frames; the second sets the offset.
        send_item(mk_frame(513, 100, 0, 0, 0));
        send_item(mk_frame(513, 200, 0, 0, 0));
        // Forward rise, then forward wrap with extreme current and speed.
        send_item(mk_frame(513, 8191, 11, -32768, 255));
        send_item(mk_frame(513, 0, 32767, 32767, 0));
        // Small moves either way count nothing.
        send_item(mk_frame(513, 30, 11, 0, 17));
        send_item(mk_frame(513, 0, 11, -5, 18));
        // Reverse wrap, then a reverse drop.
        send_item(mk_frame(513, 8000, -11, 4, 19));
        send_item(mk_frame(513, 7000, -32768, 5, 20));
        // Speed exactly on the threshold trusts no direction.
        send_item(mk_frame(513, 100, 10, -4, 21));
        send_item(mk_frame(513, 8100, -10, -6, 22));
        // Changes of exactly the jump threshold.
        send_item(mk_frame(513, 8050, 11, 6, 23));
        send_item(mk_frame(513, 8100, -11, 7, 24));
        send_item(mk_frame(513, 8150, -11, 8, 25));
        // Last motor of the group, and a calibration frame of another.
        send_item(mk_frame(516, 5, 0, 9, 26));
        send_item(mk_frame(516, 6, 0, 10, 27));
        send_item(mk_frame(516, 8191, 0, 11, 28));
        send_item(mk_frame(514, 1234, 0, 12, 29));
        // Clear in the middle: motor zero calibrates again.
        random_fields(it);
        it.req_type = REQ_CLEAR;
        send_item(it);
        send_item(mk_frame(513, 10, 11, 13, 30));
        send_item(mk_frame(513, 20, 11, 14, 31));
        send_item(mk_frame(513, 30, 11, 15, 32));
    endtask

    // With calibration at the top every frame calibrates, even after the
    // frame counter has stopped; one step lower the stuck counter lets
    // frames through.
    task automatic test_counter_top();
        mfmd_item_t it;
        set_config(10, 50, 63, 513);
        random_fields(it);
        it.req_type = REQ_CLEAR;
        send_item(it);
        for (int i = 0; i < 70; i++)
        begin
            random_fields(it);
            it.frame_id = ID_W'(514);
            send_item(it);
        end
        set_config(10, 50, 62, 513);
        for (int i = 0; i < 10; i++)
        begin
            random_fields(it);
            it.frame_id = ID_W'(514);
            send_item(it);
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the pipeline fills up and the input has to stall.
    task automatic test_backpressure();
        mfmd_item_t it;
        set_config(5, 100, 0, 300);
        idle_mode = IDLE_NONE;
        hold_req_id = hold_req_id + 1;
        for (int i = 0; i < 40; i++)
        begin
            make_traffic_item(it);
            send_item(it);
        end
    endtask

    task automatic test_random_traffic(input idle_mode_e mode, input int unsigned spin,
                                       input int unsigned jump, input int unsigned calib,
                                       input int unsigned base, input int n_items);
        mfmd_item_t it;
        int         sent;
        int         made_before;
        set_config(spin, jump, calib, base);
        idle_mode   = mode;
        made_before = results_predicted;
        sent        = 0;
        while (sent < n_items || results_predicted - made_before < 24)
        begin
            make_traffic_item(it);
            send_item(it);
            sent++;
        end
    endtask

    // Counts a run of turns up on one motor, then after a clear a run down.
    // With both thresholds zero every one-count step against the usual
    // direction of the angle counts a turn, so the totals go far from zero.
    task automatic test_turn_runs();
        mfmd_item_t it;
        logic [ANGLE_W-1:0] ang;
        set_config(0, 0, 0, 1000);
        idle_mode = IDLE_NONE;
        random_fields(it);
        it.req_type = REQ_CLEAR;
        send_item(it);
        ang = '1;
        for (int i = 0; i < RUN_FRAMES; i++)
        begin
            random_fields(it);
            it.frame_id    = ID_W'(1002);
            it.rotor_angle = ang;
            it.speed_word  = WORD_W'($urandom_range(1, 32767));
            send_item(it);
            ang = ang - 1'b1;
        end
        random_fields(it);
        it.req_type = REQ_CLEAR;
        send_item(it);
        ang = '0;
        for (int i = 0; i < RUN_FRAMES; i++)
        begin
            random_fields(it);
            it.frame_id    = ID_W'(1002);
            it.rotor_angle = ang;
            it.speed_word  = WORD_W'(-int'($urandom_range(1, 32768)));
            send_item(it);
            ang = ang + 1'b1;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        model_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_counter_top();
        test_backpressure();

        // Register extremes first, then random settings; the unused upper
        // bits of the configuration data carry garbage in the random ones.
        test_random_traffic(IDLE_NONE, 0, 0, 0, 0, 90);
        test_random_traffic(IDLE_SENDER, 32767, 8191, 0, 2047, 90);
        test_random_traffic(IDLE_RECEIVER, 1, 8191, 3, 2044, 90);
        test_random_traffic(IDLE_BOTH, 0, 0, 1, 2045, 90);
        for (int p = 0; p < 4; p++)
            test_random_traffic(idle_mode_e'(p),
                                $urandom_range(0, 300),
                                $urandom_range(0, 4095) | ($urandom_range(0, 3) << JUMP_W),
                                $urandom_range(0, 3) | ($urandom_range(0, 511) << CNT_W),
                                $urandom_range(0, 2047) | ($urandom_range(0, 15) << ID_W),
                                90);

        test_turn_runs();

        wait_drain();
        if (err_count == 0)
            $display("[motor_feedback_multiturn_decoder_core] OK");
        else
            $display("[motor_feedback_multiturn_decoder_core] ERROR");
        $finish;
    end

endmodule

>>> files.f
src/mfmd_pkg.sv
src/mfmd_cfg.sv
src/mfmd_unwrap.sv
src/motor_feedback_multiturn_decoder_core.sv
src/mfmd_checker.sv
dv/tb_top.sv
